/* src/srec_pkg.sv */
`timescale 1ns / 1ps

package srec_pkg;

   // largest record payload honored, whatever the register holds
   localparam int MAX_RECORD = 128;

   localparam logic [7:0] RECORD_MAX_RESET = 8'd128;

   // item kinds
   localparam logic ACTION_BEGIN = 1'b0;
   localparam logic ACTION_DATA  = 1'b1;

   // ascii codes
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_CR   = 8'h0D;

   // address thresholds that pick S3 and S2 records
   localparam logic [31:0] ADDR_S3_MIN = 32'h00FF_FFFF;
   localparam logic [31:0] ADDR_S2_MIN = 32'h0000_FFFF;

   // S7 trailer plus its CR, fifteen characters
   localparam logic [3:0] TRAILER_LAST = 4'd14;

   // one job handed from the front to the back
   typedef struct packed {
      logic        has_hdr;
      logic        has_data;
      logic        has_sum;
      logic        has_trail;
      logic [2:0]  alen;
      logic [7:0]  len_byte;
      logic [31:0] addr;      // left aligned, first nibble in [31:28]
      logic [7:0]  data;
      logic [7:0]  sum;
   } job_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + wide;
      end
      return 8'h37 + wide;
   endfunction

   function automatic logic [7:0] trailer_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = CHAR_S;
         4'd1:    ch = 8'h37;
         4'd3:    ch = 8'h35;
         4'd12:   ch = 8'h46;
         4'd13:   ch = 8'h41;
         4'd14:   ch = CHAR_CR;
         default: ch = CHAR_ZERO;
      endcase
      return ch;
   endfunction

endpackage

/* src/srec_if.sv */
`timescale 1ns / 1ps

// input channel
interface srec_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] start_address;
   logic [31:0] total_length;
   logic [7:0]  data_byte;

   modport source (output valid, action, start_address, total_length, data_byte,
                   input ready);
   modport sink (input valid, action, start_address, total_length, data_byte,
                 output ready);
endinterface

// result channel
interface srec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, out_char, last, input ready);
   modport sink (input valid, out_char, last, output ready);
endinterface

// register write channel
interface srec_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* src/srecord_download_encoder.sv */
`timescale 1ns / 1ps
// The first character of an item reaches rsp through the job queue, the back's job and
// state registers and the output register. Throughput: one character per cycle while
// rsp is not stalled; a data byte is two characters, a record header
// adds up to twelve, a record end three and the trailer fifteen. Input is taken every
// cycle while the job queue has room, so items can come back to back.
// Reset (synchronous, active high): transfer closed, queue and output empty, record_max 128.

module srecord_download_encoder import srec_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   srec_req_if.sink   req_if,
   srec_rsp_if.source rsp_if,
   srec_csr_if.sink   csr_if
);

   logic    q_push_valid;
   logic    q_push_ready;
   job_type q_push_data;
   logic    q_pop_valid;
   logic    q_pop_ready;
   job_type q_pop_data;

   // classify items and keep transfer state
   srec_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_if.valid),
      .req_ready         (req_if.ready),
      .req_action        (req_if.action),
      .req_start_address (req_if.start_address),
      .req_total_length  (req_if.total_length),
      .req_data_byte     (req_if.data_byte),
      .csr_valid         (csr_if.valid),
      .csr_ready         (csr_if.ready),
      .csr_data          (csr_if.data),
      .job_valid         (q_push_valid),
      .job_data          (q_push_data),
      .job_ready         (q_push_ready)
   );

   // job queue between front and back
   srec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   // character sequencer and output register
   srec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (q_pop_valid),
      .job_data     (q_pop_data),
      .job_ready    (q_pop_ready),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_out_char (rsp_if.out_char),
      .rsp_last     (rsp_if.last)
   );

   // back never takes a job the queue does not hold
   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      q_pop_ready |-> q_pop_valid)
      else $error("back took a job from an empty queue");

   // a pushed job is visible to the back next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (q_push_valid && q_push_ready) |=> q_pop_valid)
      else $error("pushed job missing from queue");

   // an empty transfer always yields a trailer job
   a_empty_begin_job: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.action == ACTION_BEGIN)
       && (req_if.total_length == 32'd0)) |=> q_pop_valid)
      else $error("empty transfer produced no trailer job");

endmodule

/* src/srec_front.sv */
`timescale 1ns / 1ps

module srec_front import srec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_start_address,
   input  logic [31:0] req_total_length,
   input  logic [7:0]  req_data_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   output logic        job_valid,
   output job_type     job_data,
   input  logic        job_ready
);

   logic [7:0]  record_max_ff, record_max_in;
   logic        open_ff, open_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] next_addr_ff, next_addr_in;
   logic [7:0]  rec_left_ff, rec_left_in;
   logic [7:0]  sum_ff, sum_in;

   logic        accept;
   logic [7:0]  lim;
   logic [7:0]  stride;
   logic [2:0]  alen;
   logic [31:0] addr_aligned;
   logic [7:0]  addr_sum;
   logic [7:0]  len_byte;
   logic        hdr;
   logic [7:0]  sum_base;
   logic [7:0]  sum_new;
   logic [7:0]  left_cur;
   logic [7:0]  left_new;
   logic [31:0] rem_new;
   logic        rec_end;
   logic        xfer_end;
   logic        empty_begin;

   assign csr_ready = 1'b1;
   assign req_ready = job_ready;
   assign accept    = req_valid && job_ready;

   // record length limit, clamped
   always_comb begin
      if (record_max_ff == 8'd0) begin
         lim = 8'd1;
      end else if (record_max_ff > 8'(MAX_RECORD)) begin
         lim = 8'(MAX_RECORD);
      end else begin
         lim = record_max_ff;
      end
   end

   // header fields for a record starting at next_addr
   always_comb begin
      stride = (remaining_ff < {24'd0, lim}) ? remaining_ff[7:0] : lim;
      if (next_addr_ff >= ADDR_S3_MIN) begin
         alen = 3'd4;
         addr_aligned = next_addr_ff;
         addr_sum = next_addr_ff[7:0] + next_addr_ff[15:8] + next_addr_ff[23:16]
                    + next_addr_ff[31:24];
      end else if (next_addr_ff >= ADDR_S2_MIN) begin
         alen = 3'd3;
         addr_aligned = {next_addr_ff[23:0], 8'd0};
         addr_sum = next_addr_ff[7:0] + next_addr_ff[15:8] + next_addr_ff[23:16];
      end else begin
         alen = 3'd2;
         addr_aligned = {next_addr_ff[15:0], 16'd0};
         addr_sum = next_addr_ff[7:0] + next_addr_ff[15:8];
      end
      len_byte = {5'd0, alen} + stride + 8'd1;
   end

   // per byte bookkeeping
   always_comb begin
      hdr      = (rec_left_ff == 8'd0);
      sum_base = hdr ? (len_byte + addr_sum) : sum_ff;
      left_cur = hdr ? stride : rec_left_ff;
      sum_new  = sum_base + req_data_byte;
      left_new = left_cur - 8'd1;
      rem_new  = remaining_ff - 32'd1;
      rec_end  = (left_new == 8'd0);
      xfer_end = (rem_new == 32'd0);
      empty_begin = (req_action == ACTION_BEGIN) && (req_total_length == 32'd0);
   end

   // job to the queue
   always_comb begin
      job_valid = req_valid && (empty_begin || ((req_action == ACTION_DATA) && open_ff));
      job_data.has_hdr   = (req_action == ACTION_DATA) && hdr;
      job_data.has_data  = (req_action == ACTION_DATA);
      job_data.has_sum   = (req_action == ACTION_DATA) && rec_end;
      job_data.has_trail = (req_action == ACTION_BEGIN) || xfer_end;
      job_data.alen      = alen;
      job_data.len_byte  = len_byte;
      job_data.addr      = addr_aligned;
      job_data.data      = req_data_byte;
      job_data.sum       = ~sum_new;
   end

   // next state
   always_comb begin
      record_max_in = csr_valid ? csr_data : record_max_ff;
      open_in       = open_ff;
      remaining_in  = remaining_ff;
      next_addr_in  = next_addr_ff;
      rec_left_in   = rec_left_ff;
      sum_in        = sum_ff;
      if (accept) begin
         if (req_action == ACTION_BEGIN) begin
            open_in      = !empty_begin;
            remaining_in = req_total_length;
            next_addr_in = req_start_address;
            rec_left_in  = 8'd0;
            sum_in       = 8'd0;
         end else if (open_ff) begin
            remaining_in = rem_new;
            next_addr_in = next_addr_ff + 32'd1;
            rec_left_in  = left_new;
            sum_in       = rec_end ? 8'd0 : sum_new;
            if (xfer_end) begin
               open_in     = 1'b0;
               rec_left_in = 8'd0;
               sum_in      = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_max_ff <= RECORD_MAX_RESET;
         open_ff       <= 1'b0;
         remaining_ff  <= 32'd0;
         next_addr_ff  <= 32'd0;
         rec_left_ff   <= 8'd0;
         sum_ff        <= 8'd0;
      end else begin
         record_max_ff <= record_max_in;
         open_ff       <= open_in;
         remaining_ff  <= remaining_in;
         next_addr_ff  <= next_addr_in;
         rec_left_ff   <= rec_left_in;
         sum_ff        <= sum_in;
      end
   end

endmodule

/* src/srec_queue.sv */
`timescale 1ns / 1ps

module srec_queue import srec_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_ready && pop_valid;

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/srec_back.sv */
`timescale 1ns / 1ps

module srec_back import srec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job_data,
   output logic       job_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_S     = 9'b000000010,
      ST_TYPE  = 9'b000000100,
      ST_LEN   = 9'b000001000,
      ST_ADDR  = 9'b000010000,
      ST_DATA  = 9'b000100000,
      ST_SUM   = 9'b001000000,
      ST_CR    = 9'b010000000,
      ST_TRAIL = 9'b100000000
   } back_state_type;

   back_state_type state_ff, state_in;
   back_state_type step_state;
   back_state_type first_state;
   job_type        job_ff, job_in;
   logic [3:0]     cnt_ff, cnt_in;
   logic [3:0]     step_cnt;
   logic [31:0]    addr_sh_ff, addr_sh_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_char_ff, rsp_char_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           emit;
   logic           done;
   logic           load;
   logic [7:0]     ch;
   logic [3:0]     addr_last;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // one character per cycle while the output slot is free
   assign emit      = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign addr_last = {job_ff.alen, 1'b0} - 4'd1;

   // character select and sequencing
   always_comb begin
      step_state = state_ff;
      step_cnt   = cnt_ff + 4'd1;
      done       = 1'b0;
      ch         = CHAR_CR;
      case (state_ff)
         ST_S: begin
            ch         = CHAR_S;
            step_state = ST_TYPE;
            step_cnt   = 4'd0;
         end
         ST_TYPE: begin
            ch         = CHAR_ZERO + {5'd0, job_ff.alen} - 8'd1;
            step_state = ST_LEN;
            step_cnt   = 4'd0;
         end
         ST_LEN: begin
            ch = hex_char(cnt_ff[0] ? job_ff.len_byte[3:0] : job_ff.len_byte[7:4]);
            if (cnt_ff[0]) begin
               step_state = ST_ADDR;
               step_cnt   = 4'd0;
            end
         end
         ST_ADDR: begin
            ch = hex_char(addr_sh_ff[31:28]);
            if (cnt_ff == addr_last) begin
               step_state = ST_DATA;
               step_cnt   = 4'd0;
            end
         end
         ST_DATA: begin
            ch = hex_char(cnt_ff[0] ? job_ff.data[3:0] : job_ff.data[7:4]);
            if (cnt_ff[0]) begin
               step_cnt = 4'd0;
               if (job_ff.has_sum) begin
                  step_state = ST_SUM;
               end else if (job_ff.has_trail) begin
                  step_state = ST_TRAIL;
               end else begin
                  done = 1'b1;
               end
            end
         end
         ST_SUM: begin
            ch = hex_char(cnt_ff[0] ? job_ff.sum[3:0] : job_ff.sum[7:4]);
            if (cnt_ff[0]) begin
               step_state = ST_CR;
               step_cnt   = 4'd0;
            end
         end
         ST_CR: begin
            ch       = CHAR_CR;
            step_cnt = 4'd0;
            if (job_ff.has_trail) begin
               step_state = ST_TRAIL;
            end else begin
               done = 1'b1;
            end
         end
         ST_TRAIL: begin
            ch = trailer_char(cnt_ff);
            if (cnt_ff == TRAILER_LAST) begin
               done = 1'b1;
            end
         end
         default: begin
            step_state = ST_IDLE;
         end
      endcase
   end

   // entry point of a fresh job
   always_comb begin
      if (job_data.has_hdr) begin
         first_state = ST_S;
      end else if (job_data.has_data) begin
         first_state = ST_DATA;
      end else begin
         first_state = ST_TRAIL;
      end
   end

   // take the next job when idle or on the last character of this one
   assign load      = job_valid && ((state_ff == ST_IDLE) || (emit && done));
   assign job_ready = load;

   // next state
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      cnt_in     = cnt_ff;
      addr_sh_in = addr_sh_ff;
      if (load) begin
         state_in   = first_state;
         job_in     = job_data;
         cnt_in     = 4'd0;
         addr_sh_in = job_data.addr;
      end else if (emit) begin
         state_in = done ? ST_IDLE : step_state;
         cnt_in   = step_cnt;
         if (state_ff == ST_ADDR) begin
            addr_sh_in = {addr_sh_ff[27:0], 4'd0};
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = ch;
         rsp_last_in  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      addr_sh_ff  <= addr_sh_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

/* tb/srecord_download_encoder_tb.sv */
`timescale 1ns / 1ps

module srecord_download_encoder_tb;
   import srec_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";
   localparam logic [8*14-1:0] TRAILER_TEXT = "S70500000000FA";

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } rsp_char_type;

   logic clock;
   logic reset;

   srec_req_if req_bus ();
   srec_rsp_if rsp_bus ();
   srec_csr_if csr_bus ();

   srecord_download_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // shadow of the encoder state
   logic [7:0]  limit_reg;
   logic        xfer_open;
   logic [31:0] bytes_owed;
   logic [31:0] addr_next;
   logic [7:0]  rec_owed;
   logic [7:0]  rec_sum;

   rsp_char_type expected_chars [$];
   logic [7:0]   pending_line [$];

   int send_idle_pct;
   int recv_stall_pct;
   int rsp_hold_cycles;
   int items_counted;
   int items_ignored;
   int chars_checked;
   int limit_writes;
   int mismatch_count;
   int idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return HEX_DIGITS[8*(15 - nib) +: 8];
   endfunction

   task automatic push_hex(input logic [7:0] v);
      pending_line.push_back(hex_digit(v[7:4]));
      pending_line.push_back(hex_digit(v[3:0]));
   endtask

   task automatic push_trailer();
      for (int k = 0; k < 14; k++) begin
         pending_line.push_back(TRAILER_TEXT[8*(13 - k) +: 8]);
      end
      pending_line.push_back(CHAR_CR);
   endtask

   // characters one accepted item must produce
   task automatic encode_item(input logic act, input logic [31:0] addr,
                              input logic [31:0] len, input logic [7:0] dbyte,
                              output logic counted);
      logic [31:0]  lim;
      logic [31:0]  stride;
      logic [31:0]  a;
      logic [7:0]   hdr_len;
      logic [7:0]   ab;
      int           alen;
      rsp_char_type item;
      pending_line.delete();
      counted = 1'b1;
      if (act == ACTION_BEGIN) begin
         addr_next = addr;
         bytes_owed = len;
         rec_owed = 8'd0;
         rec_sum = 8'd0;
         if (len == 32'd0) begin
            xfer_open = 1'b0;
            push_trailer();
         end else begin
            xfer_open = 1'b1;
         end
      end else if (!xfer_open) begin
         counted = 1'b0;
      end else begin
         // header goes out with the first byte of a record
         if (rec_owed == 8'd0) begin
            lim = {24'd0, limit_reg};
            if (lim == 32'd0) lim = 32'd1;
            if (lim > MAX_RECORD) lim = MAX_RECORD;
            stride = (bytes_owed < lim) ? bytes_owed : lim;
            a = addr_next;
            if (a >= ADDR_S3_MIN) alen = 4;
            else if (a >= ADDR_S2_MIN) alen = 3;
            else alen = 2;
            pending_line.push_back(CHAR_S);
            pending_line.push_back(CHAR_ZERO + 8'(alen - 1));
            hdr_len = 8'(alen + stride + 1);
            push_hex(hdr_len);
            rec_sum = hdr_len;
            for (int k = alen; k > 0; k--) begin
               ab = 8'(a >> (8 * (k - 1)));
               push_hex(ab);
               rec_sum = rec_sum + ab;
            end
            rec_owed = stride[7:0];
         end
         push_hex(dbyte);
         rec_sum = rec_sum + dbyte;
         rec_owed = rec_owed - 8'd1;
         bytes_owed = bytes_owed - 32'd1;
         addr_next = addr_next + 32'd1;
         // record closes with checksum and CR
         if (rec_owed == 8'd0) begin
            push_hex(~rec_sum);
            pending_line.push_back(CHAR_CR);
            rec_sum = 8'd0;
         end
         if (bytes_owed == 32'd0) begin
            push_trailer();
            xfer_open = 1'b0;
            rec_owed = 8'd0;
            rec_sum = 8'd0;
         end
      end
      foreach (pending_line[i]) begin
         item.ch = pending_line[i];
         item.last = (i == pending_line.size() - 1);
         expected_chars.push_back(item);
      end
   endtask

   // one input transaction, called at a falling edge
   task automatic send_item(input logic act, input logic [31:0] addr,
                            input logic [31:0] len, input logic [7:0] dbyte);
      logic counted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.start_address <= addr;
      req_bus.total_length <= len;
      req_bus.data_byte <= dbyte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      encode_item(act, addr, len, dbyte, counted);
      if (counted) items_counted++;
      else items_ignored++;
      @(negedge clock);
   endtask

   task automatic send_begin(input logic [31:0] addr, input logic [31:0] len);
      send_item(ACTION_BEGIN, addr, len, 8'($urandom));
   endtask

   task automatic send_data(input logic [7:0] dbyte);
      send_item(ACTION_DATA, $urandom, $urandom, dbyte);
   endtask

   task automatic send_bytes(input int count);
      for (int i = 0; i < count; i++) send_data(8'($urandom));
   endtask

   // hold the input and let every expected character arrive
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      limit_reg = value;
      limit_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_address();
      case ($urandom_range(4))
         0: return $urandom_range(32'h0000_FFF0);
         1: return 32'h0000_FFFC + $urandom_range(6);
         2: return 32'h00FF_FFFC + $urandom_range(6);
         3: return 32'hFFFF_FFFC + $urandom_range(6);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_limit();
      if ($urandom_range(3) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(1, 8));
   endfunction

   // receiver ready, with a long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each result transaction with the oldest expected character
   always @(posedge clock) begin
      rsp_char_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected char %h last %b at %0t",
                        rsp_bus.out_char, rsp_bus.last, $realtime);
         end else begin
            want = expected_chars.pop_front();
            if (want.ch !== rsp_bus.out_char || want.last !== rsp_bus.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("char %0d: expected %h last %b, got %h last %b at %0t",
                           chars_checked, want.ch, want.last, rsp_bus.out_char,
                           rsp_bus.last, $realtime);
            end
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d chars outstanding",
                     STALL_LIMIT, expected_chars.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // stray data, and an empty transfer that gives only the trailer
   task automatic test_ignored_and_empty();
      send_item(ACTION_DATA, 32'd0, 32'd0, 8'h00);
      send_item(ACTION_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      send_begin(32'hFFFF_FFFF, 32'd0);
   endtask

   // record type changes at both thresholds and on address wrap
   task automatic test_address_widths();
      wait_drain();
      write_limit(8'd1);
      send_begin(32'h0000_FFFE, 32'd2);
      send_data(8'h00);
      send_data(8'hFF);
      send_begin(32'h00FF_FFFE, 32'd2);
      send_data(8'hA5);
      send_data(8'h5A);
      send_begin(32'hFFFF_FFFF, 32'd2);
      send_data(8'h0F);
      send_data(8'hF0);
   endtask

   // a begin drops the open transfer and its partial record
   task automatic test_restart();
      wait_drain();
      write_limit(RECORD_MAX_RESET);
      send_begin(32'h0000_1234, 32'hFFFF_FFFF);
      send_data(8'h00);
      send_data(8'hFF);
      send_begin(32'h0001_0000, 32'd1);
      send_data(8'h3C);
   endtask

   // a new limit applies from the next record on
   task automatic test_limit_change();
      wait_drain();
      write_limit(8'd4);
      send_begin(32'h0000_0100, 32'd6);
      send_bytes(2);
      wait_drain();
      write_limit(8'd2);
      send_bytes(4);
   endtask

   // a zero limit acts as one byte per record
   task automatic test_zero_limit();
      wait_drain();
      write_limit(8'd0);
      send_begin(32'd0, 32'd2);
      send_bytes(2);
   endtask

   // limit above the maximum is clamped
   task automatic test_long_records();
      int len;
      len = $urandom_range(130, 160);
      wait_drain();
      write_limit(8'hFF);
      send_begin(pick_address(), len);
      send_bytes(len);
   endtask

   // receiver holds off while the sender keeps going
   task automatic test_backpressure();
      wait_drain();
      write_limit(8'd16);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      send_begin(pick_address(), 32'd40);
      send_bytes(40);
      wait_drain();
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct,
                                   input logic [7:0] first_limit, input int target);
      int goal;
      int len;
      int kind;
      goal = items_counted + target;
      wait_drain();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      write_limit(first_limit);
      while (items_counted < goal) begin
         if ($urandom_range(7) == 0) begin
            wait_drain();
            write_limit(pick_limit());
         end
         kind = $urandom_range(9);
         if (kind < 7) begin
            len = $urandom_range(1, 12);
            send_begin(pick_address(), len);
            send_bytes(len);
         end else if (kind == 7) begin
            send_begin(pick_address(), 32'd0);
         end else if (kind == 8) begin
            // broken transfer, cut off by whatever begins next
            send_begin(pick_address(), $urandom | 32'd16);
            send_bytes($urandom_range(0, 4));
         end else begin
            send_data(8'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 8'd1, 55);
      run_random_phase(65, 0, RECORD_MAX_RESET, 55);
      run_random_phase(0, 65, 8'($urandom_range(2, 16)), 55);
      run_random_phase(18, 18, 8'd0, 55);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACTION_BEGIN;
      req_bus.start_address = 32'd0;
      req_bus.total_length = 32'd0;
      req_bus.data_byte = 8'd0;
      csr_bus.valid = 1'b0;
      csr_bus.data = 8'd0;
      rsp_bus.ready = 1'b0;
      limit_reg = RECORD_MAX_RESET;
      xfer_open = 1'b0;
      bytes_owed = 32'd0;
      addr_next = 32'd0;
      rec_owed = 8'd0;
      rec_sum = 8'd0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      rsp_hold_cycles = 0;
      items_counted = 0;
      items_ignored = 0;
      chars_checked = 0;
      limit_writes = 0;
      mismatch_count = 0;
      idle_cycles = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_ignored_and_empty();
      test_address_widths();
      test_restart();
      test_limit_change();
      test_zero_limit();
      test_long_records();
      test_backpressure();
      test_random_traffic();
      wait_drain();

      if (expected_chars.size() != 0) mismatch_count += expected_chars.size();
      $display("%0d items encoded, %0d stray data ignored, %0d chars checked, %0d limit writes",
               items_counted, items_ignored, chars_checked, limit_writes);
      $display("covered S1/S2/S3 records, address wrap, restarts, empty transfers, %s",
               "limits 0 to 255, and a long output hold-off");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/srec_pkg.sv
src/srec_if.sv
src/srec_front.sv
src/srec_queue.sv
src/srec_back.sv
src/srecord_download_encoder.sv
tb/srecord_download_encoder_tb.sv
